/* hdl/cau_pkg.sv */
`default_nettype none
package cau_pkg;

  localparam int DATA_WIDTH = 16;
  localparam int FRAC_BITS  = 8;
  localparam int PROD_W     = 2 * DATA_WIDTH;
  localparam int SUM_W      = PROD_W + 1;
  localparam int REM_W      = 3 * DATA_WIDTH + 2;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_SAT = 2'd1;
  localparam logic [1:0] ST_DZ  = 2'd2;

  typedef struct packed {
    logic [1:0]                   opcode;
    logic signed [DATA_WIDTH-1:0] a_re;
    logic signed [DATA_WIDTH-1:0] a_im;
    logic signed [DATA_WIDTH-1:0] b_re;
    logic signed [DATA_WIDTH-1:0] b_im;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] res_re;
    logic signed [DATA_WIDTH-1:0] res_im;
    logic [1:0]                   status;
  } out_item_t;

  // one beat travelling down the divider row
  typedef struct packed {
    logic                  vld;
    logic                  is_div;
    logic                  ovf_re;
    logic                  ovf_im;
    logic                  neg_re;
    logic                  neg_im;
    logic [REM_W-1:0]      den;
    logic [REM_W-1:0]      rem_re;
    logic [REM_W-1:0]      rem_im;
    logic [DATA_WIDTH-1:0] q_re;
    logic [DATA_WIDTH-1:0] q_im;
    out_item_t             pre;
  } cell_t;

  typedef struct packed {
    logic                  clip;
    logic [DATA_WIDTH-1:0] val;
  } sat_t;

  function automatic sat_t sat_fn(input logic signed [REM_W-1:0] v);
    sat_t                    r;
    logic signed [REM_W-1:0] hi;
    logic signed [REM_W-1:0] lo;
    hi = (REM_W'(1) <<< (DATA_WIDTH - 1)) - REM_W'(1);
    lo = -hi - REM_W'(1);
    if (v > hi) begin
      r.clip = 1'b1;
      r.val  = hi[DATA_WIDTH-1:0];
    end else if (v < lo) begin
      r.clip = 1'b1;
      r.val  = lo[DATA_WIDTH-1:0];
    end else begin
      r.clip = 1'b0;
      r.val  = v[DATA_WIDTH-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* hdl/cau_cell.sv */
`default_nettype none
module cau_cell #(
  parameter int SHIFT = 0
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire cau_pkg::cell_t cell_in,
  output cau_pkg::cell_t      cell_out
);
  import cau_pkg::*;

  cell_t            cell_r;
  cell_t            cell_nxt;
  logic [REM_W-1:0] den_sh;
  logic [REM_W:0]   diff_re;
  logic [REM_W:0]   diff_im;

  // one restoring step per part: subtract the shifted divisor if it fits
  always_comb begin
    den_sh   = cell_in.den << SHIFT;
    diff_re  = {1'b0, cell_in.rem_re} - {1'b0, den_sh};
    diff_im  = {1'b0, cell_in.rem_im} - {1'b0, den_sh};
    cell_nxt = cell_in;
    if (!diff_re[REM_W]) begin
      cell_nxt.rem_re      = diff_re[REM_W-1:0];
      cell_nxt.q_re[SHIFT] = 1'b1;
    end
    if (!diff_im[REM_W]) begin
      cell_nxt.rem_im      = diff_im[REM_W-1:0];
      cell_nxt.q_im[SHIFT] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    cell_r <= cell_nxt;
    if (!rst_n) begin
      cell_r.vld <= 1'b0;
    end
  end

  assign cell_out = cell_r;

endmodule
`default_nettype wire

/* hdl/complex_arithmetic_unit.sv */
`default_nettype none
// Channel   Ports                       Beat taken when
// input     start, busy, in_data        start high and busy low
// result    out_valid, out_data         out_valid high (one cycle)
//
// One beat enters every cycle; busy stays low.
// Every opcode takes the same path: five front stages
// (capture, products, sums, magnitude, overflow test) and one divider cell
// per quotient bit, then the output register.
// Reset clears only the valid bits of the pipeline.
// The receiver cannot stall, so nothing holds inside the pipeline.
module complex_arithmetic_unit (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire cau_pkg::in_item_t in_data,
  output logic                   out_valid,
  output cau_pkg::out_item_t     out_data
);
  import cau_pkg::*;

  localparam logic [DATA_WIDTH-1:0] Q_HALF = {1'b1, {(DATA_WIDTH-1){1'b0}}};
  localparam logic [DATA_WIDTH-1:0] Q_MAX  = {1'b0, {(DATA_WIDTH-1){1'b1}}};

  // stage 1: capture
  logic     vld1_r;
  in_item_t in_r;

  // stage 2: products
  logic                     vld2_r;
  logic [1:0]               op2_r;
  logic signed [PROD_W-1:0] p_rr_r, p_ii_r, p_ri_r, p_ir_r, bb_r_r, bb_i_r;
  out_item_t                pre2_r;
  logic signed [REM_W-1:0]  as_re, as_im;
  sat_t                     as_sat_re, as_sat_im;

  // stage 3: sums
  logic                    vld3_r;
  logic [1:0]              op3_r;
  logic signed [SUM_W-1:0] num_re3_r, num_im3_r, den3_r;
  out_item_t               pre3_r;
  logic signed [SUM_W-1:0] mul_re, mul_im;
  sat_t                    mul_sat_re, mul_sat_im;

  // stage 4 and 5: magnitude, overflow test
  cell_t            c4_nxt, c4_r, c5_nxt, c5_r;
  logic [SUM_W-1:0] mag_re, mag_im;

  cell_t chain [0:DATA_WIDTH];

  // output
  cell_t     last;
  out_item_t fin;
  logic      clip_re, clip_im;
  logic      out_valid_r;
  out_item_t out_data_r;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    in_r <= in_data;
    if (!rst_n) begin
      vld1_r <= 1'b0;
    end else begin
      vld1_r <= start;
    end
  end

  always_comb begin
    if (in_r.opcode == OP_SUB) begin
      as_re = REM_W'(in_r.a_re) - REM_W'(in_r.b_re);
      as_im = REM_W'(in_r.a_im) - REM_W'(in_r.b_im);
    end else begin
      as_re = REM_W'(in_r.a_re) + REM_W'(in_r.b_re);
      as_im = REM_W'(in_r.a_im) + REM_W'(in_r.b_im);
    end
    as_sat_re = sat_fn(as_re);
    as_sat_im = sat_fn(as_im);
  end

  always_ff @(posedge clk) begin
    op2_r         <= in_r.opcode;
    p_rr_r        <= $signed(in_r.a_re) * $signed(in_r.b_re);
    p_ii_r        <= $signed(in_r.a_im) * $signed(in_r.b_im);
    p_ri_r        <= $signed(in_r.a_re) * $signed(in_r.b_im);
    p_ir_r        <= $signed(in_r.a_im) * $signed(in_r.b_re);
    bb_r_r        <= $signed(in_r.b_re) * $signed(in_r.b_re);
    bb_i_r        <= $signed(in_r.b_im) * $signed(in_r.b_im);
    pre2_r.res_re <= as_sat_re.val;
    pre2_r.res_im <= as_sat_im.val;
    pre2_r.status <= (as_sat_re.clip || as_sat_im.clip) ? ST_SAT : ST_OK;
    if (!rst_n) begin
      vld2_r <= 1'b0;
    end else begin
      vld2_r <= vld1_r;
    end
  end

  // arithmetic shift right floors
  always_comb begin
    mul_re     = (SUM_W'(p_rr_r) - SUM_W'(p_ii_r)) >>> FRAC_BITS;
    mul_im     = (SUM_W'(p_ri_r) + SUM_W'(p_ir_r)) >>> FRAC_BITS;
    mul_sat_re = sat_fn(REM_W'(mul_re));
    mul_sat_im = sat_fn(REM_W'(mul_im));
  end

  always_ff @(posedge clk) begin
    op3_r     <= op2_r;
    num_re3_r <= SUM_W'(p_rr_r) + SUM_W'(p_ii_r);
    num_im3_r <= SUM_W'(p_ir_r) - SUM_W'(p_ri_r);
    den3_r    <= SUM_W'(bb_r_r) + SUM_W'(bb_i_r);
    if (op2_r == OP_MUL) begin
      pre3_r.res_re <= mul_sat_re.val;
      pre3_r.res_im <= mul_sat_im.val;
      pre3_r.status <= (mul_sat_re.clip || mul_sat_im.clip) ? ST_SAT : ST_OK;
    end else begin
      pre3_r <= pre2_r;
    end
    if (!rst_n) begin
      vld3_r <= 1'b0;
    end else begin
      vld3_r <= vld2_r;
    end
  end

  always_comb begin
    mag_re = num_re3_r[SUM_W-1] ? SUM_W'(-num_re3_r) : SUM_W'(num_re3_r);
    mag_im = num_im3_r[SUM_W-1] ? SUM_W'(-num_im3_r) : SUM_W'(num_im3_r);
    c4_nxt        = '0;
    c4_nxt.vld    = vld3_r;
    c4_nxt.neg_re = num_re3_r[SUM_W-1];
    c4_nxt.neg_im = num_im3_r[SUM_W-1];
    c4_nxt.den    = REM_W'(unsigned'(den3_r));
    c4_nxt.rem_re = REM_W'(mag_re) << FRAC_BITS;
    c4_nxt.rem_im = REM_W'(mag_im) << FRAC_BITS;
    c4_nxt.pre    = pre3_r;
    if (op3_r == OP_DIV) begin
      if (den3_r == '0) begin
        c4_nxt.pre = '{res_re: '0, res_im: '0, status: ST_DZ};
      end else begin
        c4_nxt.is_div = 1'b1;
      end
    end
  end

  // quotient needs more than DATA_WIDTH bits: saturate
  always_comb begin
    c5_nxt        = c4_r;
    c5_nxt.ovf_re = c4_r.rem_re >= (c4_r.den << DATA_WIDTH);
    c5_nxt.ovf_im = c4_r.rem_im >= (c4_r.den << DATA_WIDTH);
  end

  always_ff @(posedge clk) begin
    c4_r <= c4_nxt;
    c5_r <= c5_nxt;
    if (!rst_n) begin
      c4_r.vld <= 1'b0;
      c5_r.vld <= 1'b0;
    end
  end

  assign chain[0] = c5_r;

  for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_cell
    cau_cell #(
      .SHIFT(DATA_WIDTH - 1 - i)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .cell_in (chain[i]),
      .cell_out(chain[i+1])
    );
  end

  always_comb begin
    last    = chain[DATA_WIDTH];
    fin     = last.pre;
    clip_re = 1'b0;
    clip_im = 1'b0;
    if (last.is_div) begin
      if (last.neg_re) begin
        clip_re    = last.ovf_re || (last.q_re > Q_HALF);
        fin.res_re = clip_re ? Q_HALF : -last.q_re;
      end else begin
        clip_re    = last.ovf_re || (last.q_re > Q_MAX);
        fin.res_re = clip_re ? Q_MAX : last.q_re;
      end
      if (last.neg_im) begin
        clip_im    = last.ovf_im || (last.q_im > Q_HALF);
        fin.res_im = clip_im ? Q_HALF : -last.q_im;
      end else begin
        clip_im    = last.ovf_im || (last.q_im > Q_MAX);
        fin.res_im = clip_im ? Q_MAX : last.q_im;
      end
      fin.status = (clip_re || clip_im) ? ST_SAT : ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= fin;
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= last.vld;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_row_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    chain[DATA_WIDTH].vld |=> out_valid)
    else $error("divider row beat not delivered");

  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == ST_DZ) |-> (out_data.res_re == '0 && out_data.res_im == '0))
    else $error("divide by zero result not cleared");

  a_dz_only_div: assert property (@(posedge clk) disable iff (!rst_n)
    (c4_r.vld && c4_r.pre.status == ST_DZ) |-> !c4_r.is_div)
    else $error("zero divisor entered the divider row");

endmodule
`default_nettype wire

/* sim/tb_top.sv */
`timescale 1ns / 100ps
module tb_top;
  import cau_pkg::*;

  localparam int LATENCY = DATA_WIDTH + 6;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_item_t  in_data = '0;
  logic      out_valid;
  out_item_t out_data;

  in_item_t  pending_ops[$];
  out_item_t expected_res[$];
  int        n_mismatch = 0;
  int        gap_left = 0;
  bit        stim_done = 1'b0;
  bit        drain_req = 1'b0;

  complex_arithmetic_unit u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_data(in_data), .out_valid(out_valid), .out_data(out_data)
  );

  always #5 clk = ~clk;

  function automatic logic signed [15:0] clamp_part(input longint v, inout bit clipped);
    if (v > 32767) begin
      clipped = 1'b1;
      return 16'sh7fff;
    end
    if (v < -32768) begin
      clipped = 1'b1;
      return -16'sd32768;
    end
    return v[15:0];
  endfunction

  // floor division by 2^FRAC_BITS
  function automatic longint floor_q(input longint v);
    return v >>> FRAC_BITS;
  endfunction

  function automatic out_item_t complex_result(input in_item_t it);
    out_item_t r;
    longint ar, ai, br, bi, re, im, d;
    bit clipped;
    ar = it.a_re; ai = it.a_im; br = it.b_re; bi = it.b_im;
    clipped = 1'b0;
    re = 0; im = 0;
    case (it.opcode)
      OP_ADD: begin re = ar + br; im = ai + bi; end
      OP_SUB: begin re = ar - br; im = ai - bi; end
      OP_MUL: begin
        re = floor_q(ar * br - ai * bi);
        im = floor_q(ar * bi + ai * br);
      end
      default: begin
        d = br * br + bi * bi;
        if (d == 0) begin
          r.res_re = '0; r.res_im = '0; r.status = ST_DZ;
          return r;
        end
        re = ((ar * br + ai * bi) * (longint'(1) << FRAC_BITS)) / d;
        im = ((ai * br - ar * bi) * (longint'(1) << FRAC_BITS)) / d;
      end
    endcase
    r.res_re = clamp_part(re, clipped);
    r.res_im = clamp_part(im, clipped);
    r.status = clipped ? ST_SAT : ST_OK;
    return r;
  endfunction

  function automatic logic [15:0] rand_part();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'(int'($urandom_range(0, 1023)) - 512);
      4: return 16'(int'($urandom_range(0, 15)) - 8);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic int rand_gap();
    if ($urandom_range(0, 99) < 55) return 0;
    if ($urandom_range(0, 99) < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic in_item_t mk(input logic [1:0] op, input logic [15:0] a_re,
                                  input logic [15:0] a_im, input logic [15:0] b_re,
                                  input logic [15:0] b_im);
    in_item_t it;
    it.opcode = op; it.a_re = a_re; it.a_im = a_im; it.b_re = b_re; it.b_im = b_im;
    return it;
  endfunction

  initial begin
    in_item_t it;
    for (int op = 0; op < 4; op++) begin
      pending_ops.push_back(mk(2'(op), 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff));
      pending_ops.push_back(mk(2'(op), 16'h8000, 16'h8000, 16'h8000, 16'h8000));
      pending_ops.push_back(mk(2'(op), 16'h8000, 16'h7fff, 16'h7fff, 16'h8000));
      pending_ops.push_back(mk(2'(op), 16'h0100, 16'hff00, 16'h0000, 16'h0001));
      pending_ops.push_back(mk(2'(op), 16'hffff, 16'h0001, 16'h0003, 16'hfffd));
    end
    // zero divisor, tiny divisor, unit divisor
    pending_ops.push_back(mk(OP_DIV, 16'h1234, 16'h8000, 16'h0000, 16'h0000));
    pending_ops.push_back(mk(OP_DIV, 16'h7fff, 16'h8000, 16'h0001, 16'h0000));
    pending_ops.push_back(mk(OP_DIV, 16'hff80, 16'h0080, 16'h0100, 16'h0000));
    pending_ops.push_back(mk(OP_MUL, 16'hffff, 16'h0000, 16'h0001, 16'h0000));
    for (int i = 0; i < 1450; i++) begin
      it.opcode = 2'($urandom);
      it.a_re = rand_part(); it.a_im = rand_part();
      it.b_re = rand_part(); it.b_im = rand_part();
      if (it.opcode == OP_DIV && $urandom_range(0, 19) == 0) begin
        it.b_re = '0; it.b_im = '0;
      end
      pending_ops.push_back(it);
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy)
        expected_res.push_back(complex_result(in_data));
      if (start && busy) begin
        // hold the beat until taken
      end else if (drain_req && pending_ops.size() == 700 &&
                   (expected_res.size() != 0 || (start && !busy))) begin
        start <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (pending_ops.size() != 0) begin
        if (pending_ops.size() == 700 && !drain_req) begin
          drain_req <= 1'b1;
          start <= 1'b0;
        end else begin
          in_data <= pending_ops.pop_front();
          start <= 1'b1;
          gap_left <= rand_gap();
        end
      end else begin
        start <= 1'b0;
        stim_done <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    out_item_t exp_r;
    if (rst_n && out_valid) begin
      if (expected_res.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("unexpected result %p", out_data);
      end else begin
        exp_r = expected_res.pop_front();
        if (out_data.res_re !== exp_r.res_re || out_data.res_im !== exp_r.res_im ||
            out_data.status !== exp_r.status) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("mismatch: expected re=%h im=%h st=%0d, got re=%h im=%h st=%0d",
                     exp_r.res_re, exp_r.res_im, exp_r.status,
                     out_data.res_re, out_data.res_im, out_data.status);
        end
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    wait (stim_done);
    wait (expected_res.size() == 0);
    repeat (LATENCY * 3) @(posedge clk);
    if (n_mismatch == 0 && expected_res.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end
endmodule

/* complex_arithmetic_unit.f */
hdl/cau_pkg.sv
hdl/cau_cell.sv
hdl/complex_arithmetic_unit.sv
sim/tb_top.sv
